// ===== src/anmf_pkg.sv =====
// Shared types and constants of the APU mixer and output filter chain.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package anmf_pkg;

  localparam int LEVEL_W       = 4;
  localparam int DMC_W         = 7;
  localparam int MIX_W         = 16;
  localparam int GAIN_W        = 16;
  localparam int COEFF_W       = 15;
  localparam int OPB_W         = 16;
  localparam int SCALE_SHIFT   = 16;
  localparam int PULSE_ENTRIES = 31;
  localparam int PULSE_IDX_W   = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS      = 3'd3;

  localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd32767;
  localparam logic [COEFF_W-1:0] FIRST_HP_RESET  = 15'd32353;
  localparam logic [COEFF_W-1:0] SECOND_HP_RESET = 15'd30836;
  localparam logic [COEFF_W-1:0] LOWPASS_RESET   = 15'd21826;

  typedef struct packed {
    logic start;
    logic scale_mode;
  } mac_ctl_t;

endpackage

// ===== src/anmf_mix_rom.sv =====
// Nonlinear mixing tables: pulse and triangle/noise/DMC lookups summed into a
// registered Q0.16 mix. Depends on anmf_pkg.
`timescale 1ns / 1ps

module anmf_mix_rom #(
  parameter int MIX_ROM_ENTRIES = 203
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [anmf_pkg::LEVEL_W-1:0]        pulse_one_level,
  input  logic [anmf_pkg::LEVEL_W-1:0]        pulse_two_level,
  input  logic [anmf_pkg::LEVEL_W-1:0]        triangle_level,
  input  logic [anmf_pkg::LEVEL_W-1:0]        noise_level,
  input  logic [anmf_pkg::DMC_W-1:0]          dmc_level,
  output logic [anmf_pkg::MIX_W-1:0]          mix
);

  localparam int TND_IDX_W = $clog2(MIX_ROM_ENTRIES);

  logic [anmf_pkg::MIX_W-1:0]       pulse_tab [anmf_pkg::PULSE_ENTRIES];
  logic [anmf_pkg::MIX_W-1:0]       tnd_tab   [MIX_ROM_ENTRIES];
  logic [anmf_pkg::PULSE_IDX_W-1:0] pulse_idx;
  logic [7:0]                       tnd_sum;
  logic [TND_IDX_W-1:0]             tnd_idx;
  logic [anmf_pkg::MIX_W:0]         mix_sum;
  logic [anmf_pkg::MIX_W-1:0]       mix_r;

  for (genvar i = 0; i < anmf_pkg::PULSE_ENTRIES; i++) begin : g_pulse
    localparam longint unsigned DEN = 64'd812800 + 64'd10000 * i;
    localparam longint unsigned VAL = (64'd9552 * i * 64'd65536 + DEN / 2) / DEN;
    assign pulse_tab[i] = VAL[anmf_pkg::MIX_W-1:0];
  end

  for (genvar i = 0; i < MIX_ROM_ENTRIES; i++) begin : g_tnd
    localparam longint unsigned DEN = 64'd2432900 + 64'd10000 * i;
    localparam longint unsigned VAL = (64'd16367 * i * 64'd65536 + DEN / 2) / DEN;
    assign tnd_tab[i] = VAL[anmf_pkg::MIX_W-1:0];
  end

  assign pulse_idx = {1'b0, pulse_one_level} + {1'b0, pulse_two_level};
  assign tnd_sum   = {4'd0, triangle_level} + {3'd0, triangle_level, 1'b0}
                   + {3'd0, noise_level, 1'b0} + {1'b0, dmc_level};
  assign tnd_idx   = TND_IDX_W'(tnd_sum);
  assign mix_sum   = {1'b0, pulse_tab[pulse_idx]} + {1'b0, tnd_tab[tnd_idx]};

  // The two table entries always sum below one in Q0.16.
  always_ff @(posedge clk) begin
    if (en) begin
      mix_r <= mix_sum[anmf_pkg::MIX_W-1:0];
    end
  end

  assign mix = mix_r;

endmodule

// ===== src/anmf_mac.sv =====
// Shared multiply-accumulate unit: registered product, then addend, shift with
// truncation toward zero and saturation to the sample width. Depends on anmf_pkg.
`timescale 1ns / 1ps

module anmf_mac #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEFF_FRAC_BITS = 15,
  parameter int A_W             = 18,
  parameter int ACC_W           = 36
) (
  input  logic                                clk,
  input  anmf_pkg::mac_ctl_t                  ctl,
  input  logic signed [A_W-1:0]               op_a,
  input  logic [anmf_pkg::OPB_W-1:0]          op_b,
  input  logic signed [ACC_W-1:0]             addend,
  output logic signed [SAMPLE_WIDTH-1:0]      result
);

  localparam int PROD_W = A_W + anmf_pkg::OPB_W + 1;

  localparam logic signed [ACC_W-1:0] BIAS_F =
    ACC_W'((64'd1 << COEFF_FRAC_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0] BIAS_S =
    ACC_W'((64'd1 << anmf_pkg::SCALE_SHIFT) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    $signed({{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_LO =
    $signed({{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}});

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  addend_r;
  logic                     scale_r;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  quot;

  assign prod_nxt = op_a * $signed({1'b0, op_b});

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod_r   <= prod_nxt;
      addend_r <= addend;
      scale_r  <= ctl.scale_mode;
    end
  end

  always_comb begin
    sum = $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r}) + addend_r;
    if (scale_r) begin
      biased = sum + (sum[ACC_W-1] ? BIAS_S : '0);
      quot   = biased >>> anmf_pkg::SCALE_SHIFT;
    end else begin
      biased = sum + (sum[ACC_W-1] ? BIAS_F : '0);
      quot   = biased >>> COEFF_FRAC_BITS;
    end
    if (quot > SAT_HI) begin
      result = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (quot < SAT_LO) begin
      result = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      result = quot[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ===== src/apu_nonlinear_mixer_filter_chain_unit.sv =====
// Top level of the APU mixer and output filter chain: sequencer, history and
// configuration registers. Depends on anmf_pkg, anmf_mix_rom and anmf_mac.
`timescale 1ns / 1ps

// Each beat of channel levels is mixed through the nonlinear tables, scaled by
// the output gain, and run through two high-pass stages and one low-pass stage.
// One multiplier is shared by the gain and the three filter stages, with a
// multiply and a post state per use; a filtered beat holds the block from
// acceptance until its low-pass result is stored. A beat with block_start set,
// or the first beat after reset, passes the scaled sample straight through.
// in_stall is high while a beat is in progress; a result that has not been
// taken only delays the end of the following beat. Configuration should be
// written while no beat is in progress.
module apu_nonlinear_mixer_filter_chain_unit #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEFF_FRAC_BITS = 15,
  parameter int MIX_ROM_ENTRIES = 203
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [anmf_pkg::LEVEL_W-1:0]         in_pulse_one_level,
  input  logic [anmf_pkg::LEVEL_W-1:0]         in_pulse_two_level,
  input  logic [anmf_pkg::LEVEL_W-1:0]         in_triangle_level,
  input  logic [anmf_pkg::LEVEL_W-1:0]         in_noise_level,
  input  logic [anmf_pkg::DMC_W-1:0]           in_dmc_level,
  input  logic                                 in_block_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]       out_filtered_sample,
  input  logic                                 cfg_wr_en,
  input  logic [anmf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [anmf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int F      = COEFF_FRAC_BITS;
  localparam int A_W    = (SW + 2 > anmf_pkg::MIX_W + 1) ? SW + 2 : anmf_pkg::MIX_W + 1;
  localparam int PROD_W = A_W + anmf_pkg::OPB_W + 1;
  localparam int ACC_W  = ((PROD_W > SW + F) ? PROD_W : SW + F) + 1;

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_SCALE_MUL  = 9'b000000010,
    ST_SCALE_POST = 9'b000000100,
    ST_HP1_MUL    = 9'b000001000,
    ST_HP1_POST   = 9'b000010000,
    ST_HP2_MUL    = 9'b000100000,
    ST_HP2_POST   = 9'b001000000,
    ST_LP_MUL     = 9'b010000000,
    ST_LP_POST    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [anmf_pkg::GAIN_W-1:0]  gain_r, gain_nxt;
  logic [anmf_pkg::COEFF_W-1:0] hp1_coeff_r, hp1_coeff_nxt;
  logic [anmf_pkg::COEFF_W-1:0] hp2_coeff_r, hp2_coeff_nxt;
  logic [anmf_pkg::COEFF_W-1:0] lp_coeff_r, lp_coeff_nxt;

  logic                 hist_valid_r, hist_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 start_r, start_nxt;
  logic signed [SW-1:0] prev_x_r, prev_x_nxt;
  logic signed [SW-1:0] prev_h1_r, prev_h1_nxt;
  logic signed [SW-1:0] prev_h2_r, prev_h2_nxt;
  logic signed [SW-1:0] prev_y_r, prev_y_nxt;
  logic signed [SW-1:0] x_r, x_nxt;
  logic signed [SW-1:0] h1_r, h1_nxt;
  logic signed [SW-1:0] h2_r, h2_nxt;
  logic signed [SW-1:0] out_sample_r, out_sample_nxt;

  logic                          in_fire;
  logic                          out_free;
  logic [anmf_pkg::MIX_W-1:0]    mix;
  anmf_pkg::mac_ctl_t            mac_ctl;
  logic signed [A_W-1:0]         op_a;
  logic [anmf_pkg::OPB_W-1:0]    op_b;
  logic signed [ACC_W-1:0]       addend;
  logic signed [SW-1:0]          mac_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_filtered_sample = out_sample_r;

  anmf_mix_rom #(
    .MIX_ROM_ENTRIES(MIX_ROM_ENTRIES)
  ) u_mix_rom (
    .clk             (clk),
    .en              (in_fire),
    .pulse_one_level (in_pulse_one_level),
    .pulse_two_level (in_pulse_two_level),
    .triangle_level  (in_triangle_level),
    .noise_level     (in_noise_level),
    .dmc_level       (in_dmc_level),
    .mix             (mix)
  );

  anmf_mac #(
    .SAMPLE_WIDTH    (SW),
    .COEFF_FRAC_BITS (F),
    .A_W             (A_W),
    .ACC_W           (ACC_W)
  ) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .op_a   (op_a),
    .op_b   (op_b),
    .addend (addend),
    .result (mac_res)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_ctl.start      = 1'b0;
    mac_ctl.scale_mode = 1'b0;
    op_a   = '0;
    op_b   = '0;
    addend = '0;
    case (state_r)
      ST_SCALE_MUL: begin
        mac_ctl.start      = 1'b1;
        mac_ctl.scale_mode = 1'b1;
        op_a = $signed({{(A_W-anmf_pkg::MIX_W){1'b0}}, mix});
        op_b = gain_r;
      end
      ST_HP1_MUL: begin
        mac_ctl.start = 1'b1;
        op_a = $signed({{(A_W-SW){prev_h1_r[SW-1]}}, prev_h1_r})
             + $signed({{(A_W-SW){x_r[SW-1]}}, x_r})
             - $signed({{(A_W-SW){prev_x_r[SW-1]}}, prev_x_r});
        op_b = {1'b0, hp1_coeff_r};
      end
      ST_HP2_MUL: begin
        mac_ctl.start = 1'b1;
        op_a = $signed({{(A_W-SW){prev_h2_r[SW-1]}}, prev_h2_r})
             + $signed({{(A_W-SW){h1_r[SW-1]}}, h1_r})
             - $signed({{(A_W-SW){prev_h1_r[SW-1]}}, prev_h1_r});
        op_b = {1'b0, hp2_coeff_r};
      end
      ST_LP_MUL: begin
        mac_ctl.start = 1'b1;
        op_a = $signed({{(A_W-SW){h2_r[SW-1]}}, h2_r})
             - $signed({{(A_W-SW){prev_y_r[SW-1]}}, prev_y_r});
        op_b = {1'b0, lp_coeff_r};
        addend = $signed({{(ACC_W-SW-F){prev_y_r[SW-1]}}, prev_y_r, {F{1'b0}}});
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    hist_valid_nxt = hist_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    start_nxt      = start_r;
    prev_x_nxt     = prev_x_r;
    prev_h1_nxt    = prev_h1_r;
    prev_h2_nxt    = prev_h2_r;
    prev_y_nxt     = prev_y_r;
    x_nxt          = x_r;
    h1_nxt         = h1_r;
    h2_nxt         = h2_r;
    gain_nxt       = gain_r;
    hp1_coeff_nxt  = hp1_coeff_r;
    hp2_coeff_nxt  = hp2_coeff_r;
    lp_coeff_nxt   = lp_coeff_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        anmf_pkg::CFG_OUTPUT_GAIN: gain_nxt      = cfg_wdata;
        anmf_pkg::CFG_FIRST_HP:    hp1_coeff_nxt = cfg_wdata[anmf_pkg::COEFF_W-1:0];
        anmf_pkg::CFG_SECOND_HP:   hp2_coeff_nxt = cfg_wdata[anmf_pkg::COEFF_W-1:0];
        anmf_pkg::CFG_LOWPASS:     lp_coeff_nxt  = cfg_wdata[anmf_pkg::COEFF_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          start_nxt = in_block_start;
          state_nxt = ST_SCALE_MUL;
        end
      end
      ST_SCALE_MUL: state_nxt = ST_SCALE_POST;
      ST_SCALE_POST: begin
        if (start_r || !hist_valid_r) begin
          // Restart: the scaled sample goes out as is and seeds all history.
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_sample_nxt = mac_res;
            prev_x_nxt     = mac_res;
            prev_h1_nxt    = mac_res;
            prev_h2_nxt    = mac_res;
            prev_y_nxt     = mac_res;
            hist_valid_nxt = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          x_nxt     = mac_res;
          state_nxt = ST_HP1_MUL;
        end
      end
      ST_HP1_MUL: state_nxt = ST_HP1_POST;
      ST_HP1_POST: begin
        h1_nxt    = mac_res;
        state_nxt = ST_HP2_MUL;
      end
      ST_HP2_MUL: state_nxt = ST_HP2_POST;
      ST_HP2_POST: begin
        h2_nxt    = mac_res;
        state_nxt = ST_LP_MUL;
      end
      ST_LP_MUL: state_nxt = ST_LP_POST;
      ST_LP_POST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = mac_res;
          prev_x_nxt     = x_r;
          prev_h1_nxt    = h1_r;
          prev_h2_nxt    = h2_r;
          prev_y_nxt     = mac_res;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hist_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      gain_r       <= anmf_pkg::GAIN_RESET;
      hp1_coeff_r  <= anmf_pkg::FIRST_HP_RESET;
      hp2_coeff_r  <= anmf_pkg::SECOND_HP_RESET;
      lp_coeff_r   <= anmf_pkg::LOWPASS_RESET;
    end else begin
      state_r      <= state_nxt;
      hist_valid_r <= hist_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      gain_r       <= gain_nxt;
      hp1_coeff_r  <= hp1_coeff_nxt;
      hp2_coeff_r  <= hp2_coeff_nxt;
      lp_coeff_r   <= lp_coeff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    out_sample_r <= out_sample_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_h1_r    <= prev_h1_nxt;
    prev_h2_r    <= prev_h2_nxt;
    prev_y_r     <= prev_y_nxt;
    x_r          <= x_nxt;
    h1_r         <= h1_nxt;
    h2_r         <= h2_nxt;
  end

endmodule
